### rtl/core/stt_pkg.sv
`timescale 1ns / 1ps
// Shared types, character codes and token kind codes for the source text tokenizer.
package stt_pkg;

	localparam int KIND_W = 5;
	localparam int LINE_W = 16;
	localparam int COL_W = 16;
	localparam int TLEN_W = 8;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_CNT_W = 3;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_NL = 8'h0A;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_EQ = 8'h3D;
	localparam logic [7:0] CH_L = 8'h6C;
	localparam logic [7:0] CH_P = 8'h70;

	localparam logic [3:0] KW_NONE = 4'd0;
	localparam logic [3:0] KW_L = 4'd1;
	localparam logic [3:0] KW_LET = 4'd3;
	localparam logic [3:0] KW_P = 4'd4;
	localparam logic [3:0] KW_PRINT = 4'd8;

	typedef enum logic [2:0] {
		MODE_IDLE = 3'd0,
		MODE_IDENT = 3'd1,
		MODE_NUMBER = 3'd2,
		MODE_STRING = 3'd3,
		MODE_EQ = 3'd4
	} lex_mode_t;

	typedef enum logic [KIND_W-1:0] {
		K_IDENT = 5'd0,
		K_LET = 5'd1,
		K_PRINT = 5'd2,
		K_NUMBER = 5'd3,
		K_STRING = 5'd4,
		K_PLUS = 5'd5,
		K_MINUS = 5'd6,
		K_MUL = 5'd7,
		K_DIV = 5'd8,
		K_ASSIGN = 5'd9,
		K_COMPARE = 5'd10,
		K_LT = 5'd11,
		K_GT = 5'd12,
		K_SEMI = 5'd13,
		K_LPAREN = 5'd14,
		K_RPAREN = 5'd15,
		K_UNKNOWN = 5'd16,
		K_EOF = 5'd17
	} token_kind_t;

	typedef struct packed {
		logic [7:0] text_char;
		logic end_of_text;
	} stt_in_t;

	typedef struct packed {
		token_kind_t token_kind;
		logic [LINE_W-1:0] start_line;
		logic [COL_W-1:0] start_column;
		logic [TLEN_W-1:0] text_length;
		logic last_of_run;
	} stt_out_t;

	function automatic token_kind_t op_kind(input logic [7:0] c);
		token_kind_t k;
		unique case (c)
			8'h2B: k = K_PLUS;
			8'h2D: k = K_MINUS;
			8'h2A: k = K_MUL;
			8'h2F: k = K_DIV;
			8'h3C: k = K_LT;
			8'h3E: k = K_GT;
			8'h3B: k = K_SEMI;
			8'h28: k = K_LPAREN;
			8'h29: k = K_RPAREN;
			default: k = K_UNKNOWN;
		endcase
		return k;
	endfunction

	// Character expected next for a given keyword prefix state, zero if none.
	function automatic logic [7:0] kw_expect(input logic [3:0] p);
		logic [7:0] ch;
		unique case (p)
			4'd1: ch = 8'h65;
			4'd2: ch = 8'h74;
			4'd4: ch = 8'h72;
			4'd5: ch = 8'h69;
			4'd6: ch = 8'h6E;
			4'd7: ch = 8'h74;
			default: ch = CH_NUL;
		endcase
		return ch;
	endfunction

endpackage

### rtl/core/stt_lex_core.sv
`timescale 1ns / 1ps
// Lexer state registers and the single-pass decode that turns one byte into up to two tokens.
module stt_lex_core #(
	parameter int POSITION_BITS = 16,
	parameter int LENGTH_BITS = 8
) (
	input logic clk,
	input logic arst_n,
	input logic step_en,
	input stt_pkg::stt_in_t item,
	output stt_pkg::stt_out_t res0,
	output stt_pkg::stt_out_t res1,
	output logic [1:0] res_count
);
	import stt_pkg::*;

	localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
	localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

	lex_mode_t mode_q, mode_d;
	logic [POSITION_BITS-1:0] line_q, line_d, col_q, col_d;
	logic [POSITION_BITS-1:0] tok_line_q, tok_line_d, tok_col_q, tok_col_d;
	logic [LENGTH_BITS-1:0] tok_len_q, tok_len_d;
	logic [3:0] kw_q, kw_d;

	logic [7:0] c;
	logic is_end, is_alpha, is_digit, is_space, is_quote, is_eq, single_op;
	logic tok_emit, tok_is_cmp, dispatch, grow, kw_adv, sec_emit;
	token_kind_t tok_kind, word_kind;
	stt_out_t r_tok, r_sec;

	assign c = item.text_char;
	assign is_end = item.end_of_text | (c == CH_NUL);
	assign is_alpha = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
	assign is_digit = (c >= 8'h30) && (c <= 8'h39);
	assign is_space = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
	assign is_quote = (c == CH_QUOTE);
	assign is_eq = (c == CH_EQ);
	assign single_op = !is_space && !is_alpha && !is_digit && !is_quote && !is_eq;
	assign word_kind = (kw_q == KW_LET) ? K_LET : ((kw_q == KW_PRINT) ? K_PRINT : K_IDENT);

	always_comb begin
		tok_emit = 1'b0;
		tok_is_cmp = 1'b0;
		tok_kind = K_IDENT;
		dispatch = 1'b0;
		grow = 1'b0;
		kw_adv = 1'b0;
		if (is_end) begin
			unique case (mode_q)
				MODE_IDENT: begin
					tok_emit = 1'b1;
					tok_kind = word_kind;
				end
				MODE_NUMBER: begin
					tok_emit = 1'b1;
					tok_kind = K_NUMBER;
				end
				MODE_STRING: begin
					tok_emit = 1'b1;
					tok_kind = K_UNKNOWN;
				end
				MODE_EQ: begin
					tok_emit = 1'b1;
					tok_kind = K_ASSIGN;
				end
				default: begin
				end
			endcase
		end else begin
			unique case (mode_q)
				MODE_IDENT: begin
					if (is_alpha) begin
						grow = 1'b1;
						kw_adv = 1'b1;
					end else begin
						tok_emit = 1'b1;
						tok_kind = word_kind;
						dispatch = 1'b1;
					end
				end
				MODE_NUMBER: begin
					if (is_digit) begin
						grow = 1'b1;
					end else begin
						tok_emit = 1'b1;
						tok_kind = K_NUMBER;
						dispatch = 1'b1;
					end
				end
				MODE_STRING: begin
					if (is_quote) begin
						tok_emit = 1'b1;
						tok_kind = K_STRING;
					end else begin
						grow = 1'b1;
					end
				end
				MODE_EQ: begin
					tok_emit = 1'b1;
					if (is_eq) begin
						tok_kind = K_COMPARE;
						tok_is_cmp = 1'b1;
					end else begin
						tok_kind = K_ASSIGN;
						dispatch = 1'b1;
					end
				end
				default: begin
					dispatch = 1'b1;
				end
			endcase
		end
	end

	assign sec_emit = is_end | (dispatch & single_op);

	// Next state.
	always_comb begin
		mode_d = mode_q;
		line_d = line_q;
		col_d = col_q;
		tok_line_d = tok_line_q;
		tok_col_d = tok_col_q;
		tok_len_d = tok_len_q;
		kw_d = kw_q;
		if (!is_end) begin
			if (c == CH_NL) begin
				if (line_q != POS_MAX) begin
					line_d = line_q + POS_ONE;
				end
				col_d = POS_ONE;
			end else if (col_q != POS_MAX) begin
				col_d = col_q + POS_ONE;
			end
		end
		if (is_end) begin
			mode_d = MODE_IDLE;
		end else if (dispatch) begin
			mode_d = MODE_IDLE;
			if (is_alpha || is_digit || is_quote || is_eq) begin
				tok_line_d = line_q;
				tok_col_d = col_q;
				tok_len_d = is_quote ? '0 : LENGTH_BITS'(1);
				if (is_alpha) begin
					mode_d = MODE_IDENT;
				end else if (is_digit) begin
					mode_d = MODE_NUMBER;
				end else if (is_quote) begin
					mode_d = MODE_STRING;
				end else begin
					mode_d = MODE_EQ;
				end
			end
			if (is_alpha) begin
				kw_d = (c == CH_L) ? KW_L : ((c == CH_P) ? KW_P : KW_NONE);
			end
		end else if (tok_emit) begin
			mode_d = MODE_IDLE;
			if (tok_is_cmp) begin
				tok_len_d = LENGTH_BITS'(2);
			end
		end
		if (grow && (tok_len_q != LEN_MAX)) begin
			tok_len_d = tok_len_q + LENGTH_BITS'(1);
		end
		if (kw_adv) begin
			if ((((kw_q == 4'd1) || (kw_q == 4'd2)) || ((kw_q >= 4'd4) && (kw_q <= 4'd7)))
					&& (c == kw_expect(kw_q))) begin
				kw_d = kw_q + 4'd1;
			end else begin
				kw_d = KW_NONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			line_q <= POS_ONE;
			col_q <= POS_ONE;
			tok_line_q <= POS_ONE;
			tok_col_q <= POS_ONE;
			tok_len_q <= '0;
			kw_q <= KW_NONE;
		end else if (step_en) begin
			mode_q <= mode_d;
			line_q <= line_d;
			col_q <= col_d;
			tok_line_q <= tok_line_d;
			tok_col_q <= tok_col_d;
			tok_len_q <= tok_len_d;
			kw_q <= kw_d;
		end
	end

	// Result assembly.
	always_comb begin
		r_tok.token_kind = tok_kind;
		r_tok.start_line = LINE_W'(tok_line_q);
		r_tok.start_column = COL_W'(tok_col_q);
		r_tok.text_length = tok_is_cmp ? TLEN_W'(2) : TLEN_W'(tok_len_q);
		r_tok.last_of_run = !sec_emit;
		r_sec.token_kind = is_end ? K_EOF : op_kind(c);
		r_sec.start_line = LINE_W'(line_q);
		r_sec.start_column = COL_W'(col_q);
		r_sec.text_length = is_end ? '0 : TLEN_W'(1);
		r_sec.last_of_run = 1'b1;
		res0 = tok_emit ? r_tok : r_sec;
		res1 = r_sec;
		res_count = {1'b0, tok_emit} + {1'b0, sec_emit};
	end

endmodule

### rtl/core/stt_token_fifo.sv
`timescale 1ns / 1ps
// Four-entry token queue that takes up to two tokens per cycle and hands out one.
module stt_token_fifo (
	input logic clk,
	input logic arst_n,
	input logic [1:0] push_n,
	input stt_pkg::stt_out_t din0,
	input stt_pkg::stt_out_t din1,
	output logic room,
	output logic token_valid,
	input logic token_ready,
	output stt_pkg::stt_out_t token
);
	import stt_pkg::*;

	stt_out_t mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wptr_q, rptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic pop;

	assign token_valid = (count_q != '0);
	assign token = mem_q[rptr_q];
	assign pop = token_valid && token_ready;
	assign room = (count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wptr_q] <= din0;
		end
		if (push_n == 2'd2) begin
			mem_q[wptr_q + FIFO_PTR_W'(1)] <= din1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			wptr_q <= wptr_q + FIFO_PTR_W'(push_n);
			rptr_q <= rptr_q + FIFO_PTR_W'(pop);
			count_q <= count_q + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
		end
	end

endmodule

### rtl/core/source_text_tokenizer.sv
`timescale 1ns / 1ps
// Top level of the streaming source text tokenizer.
//
// The text channel carries one source byte per request (text_char, with
// end_of_text marking the end of input; a zero byte counts as end too).
// The token channel carries one token per request: kind, start line and
// column, a saturating text length, and last_of_run on the final token that
// a given byte caused. A byte causes zero, one or two tokens.
// A request is taken into an input register, then decoded against the
// lexer state and written into a four-entry token queue once the queue has
// room for two tokens; the tokens of a byte are offered from the queue.
// One byte is accepted per cycle while the queue has room for two tokens;
// bytes that cause two tokens can stall the input when the output drains
// one token per cycle.
// Reset puts the lexer between tokens at line 1, column 1 and empties the
// queue. When the receiver stalls, the queue fills and text_ready drops;
// nothing is lost or repeated.
module source_text_tokenizer #(
	parameter int POSITION_BITS = 16,
	parameter int LENGTH_BITS = 8
) (
	input logic clk,
	input logic arst_n,
	input logic text_valid,
	output logic text_ready,
	input stt_pkg::stt_in_t text,
	output logic token_valid,
	input logic token_ready,
	output stt_pkg::stt_out_t token
);
	import stt_pkg::*;

	logic s1_valid_q;
	stt_in_t s1_data_q;
	logic room, process;
	logic [1:0] res_count, push_n;
	stt_out_t res0, res1;

	assign process = s1_valid_q && room;
	assign text_ready = !s1_valid_q || process;
	assign push_n = process ? res_count : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (text_ready) begin
			s1_valid_q <= text_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_ready && text_valid) begin
			s1_data_q <= text;
		end
	end

	stt_lex_core #(
		.POSITION_BITS(POSITION_BITS),
		.LENGTH_BITS(LENGTH_BITS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.step_en(process),
		.item(s1_data_q),
		.res0(res0),
		.res1(res1),
		.res_count(res_count)
	);

	stt_token_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push_n(push_n),
		.din0(res0),
		.din1(res1),
		.room(room),
		.token_valid(token_valid),
		.token_ready(token_ready),
		.token(token)
	);

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !process |=> s1_valid_q && $stable(s1_data_q))
		else $error("held request changed while waiting for queue room");

	a_end_gives_token: assert property (@(posedge clk) disable iff (!arst_n)
		process && s1_data_q.end_of_text |-> push_n != 2'd0)
		else $error("end of text produced no token");

	a_pair_first_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		process && push_n == 2'd2 |-> !res0.last_of_run && res1.last_of_run)
		else $error("last_of_run wrong on a token pair");

	a_single_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		process && push_n == 2'd1 |-> res0.last_of_run)
		else $error("single token not marked last_of_run");

endmodule

### verif/source_text_tokenizer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for source_text_tokenizer: source text against a token predictor.
module source_text_tokenizer_tb;
	import stt_pkg::*;

	localparam int HALF_PERIOD = 4;
	localparam int RESET_CYCLES = 9;
	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 16;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_REQUESTS = 80;
	localparam logic [LINE_W-1:0] LINE_MAX = '1;
	localparam logic [COL_W-1:0] COL_MAX = '1;
	localparam logic [TLEN_W-1:0] TLEN_MAX = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic text_valid = 1'b0;
	logic text_ready;
	stt_in_t text = '0;
	logic token_valid;
	logic token_ready = 1'b0;
	stt_out_t token;

	lex_mode_t lx_mode;
	logic [LINE_W-1:0] cur_line;
	logic [COL_W-1:0] cur_col;
	logic [LINE_W-1:0] tok_line;
	logic [COL_W-1:0] tok_col;
	logic [TLEN_W-1:0] tok_len;
	logic [3:0] kw_state;

	stt_out_t run_tokens[$];
	stt_out_t tokens_due[$];
	stt_out_t next_token;

	int failures = 0;
	int requests_sent = 0;
	int cycle_count = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;

	source_text_tokenizer #(
		.POSITION_BITS(16),
		.LENGTH_BITS(8)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.text_valid(text_valid),
		.text_ready(text_ready),
		.text(text),
		.token_valid(token_valid),
		.token_ready(token_ready),
		.token(token)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c == " " || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic token_kind_t single_kind(input logic [7:0] c);
		case (c)
			"+": return K_PLUS;
			"-": return K_MINUS;
			"*": return K_MUL;
			"/": return K_DIV;
			"<": return K_LT;
			">": return K_GT;
			";": return K_SEMI;
			"(": return K_LPAREN;
			")": return K_RPAREN;
			default: return K_UNKNOWN;
		endcase
	endfunction

	task automatic reset_lexer();
		lx_mode = MODE_IDLE;
		cur_line = LINE_W'(1);
		cur_col = COL_W'(1);
		tok_line = LINE_W'(1);
		tok_col = COL_W'(1);
		tok_len = '0;
		kw_state = KW_NONE;
	endtask

	task automatic add_token(input token_kind_t kind, input logic [LINE_W-1:0] ln,
			input logic [COL_W-1:0] col, input logic [TLEN_W-1:0] len);
		stt_out_t t;
		t.token_kind = kind;
		t.start_line = ln;
		t.start_column = col;
		t.text_length = len;
		t.last_of_run = 1'b0;
		run_tokens.push_back(t);
	endtask

	task automatic move_pos(input logic [7:0] c);
		if (c == CH_NL) begin
			if (cur_line != LINE_MAX)
				cur_line++;
			cur_col = COL_W'(1);
		end else if (cur_col != COL_MAX) begin
			cur_col++;
		end
	endtask

	task automatic begin_token(input lex_mode_t mode, input logic [TLEN_W-1:0] len);
		lx_mode = mode;
		tok_line = cur_line;
		tok_col = cur_col;
		tok_len = len;
	endtask

	task automatic grow_length();
		if (tok_len != TLEN_MAX)
			tok_len++;
	endtask

	task automatic track_keyword(input logic [7:0] c);
		logic [7:0] want;
		case (kw_state)
			KW_L: want = "e";
			KW_L + 4'd1: want = "t";
			KW_P: want = "r";
			KW_P + 4'd1: want = "i";
			KW_P + 4'd2: want = "n";
			KW_P + 4'd3: want = "t";
			default: want = CH_NUL;
		endcase
		kw_state = (want != CH_NUL && c == want) ? kw_state + 4'd1 : KW_NONE;
	endtask

	function automatic token_kind_t word_kind();
		if (kw_state == KW_LET)
			return K_LET;
		if (kw_state == KW_PRINT)
			return K_PRINT;
		return K_IDENT;
	endfunction

	task automatic close_token(input token_kind_t kind);
		add_token(kind, tok_line, tok_col, tok_len);
		lx_mode = MODE_IDLE;
	endtask

	task automatic start_char(input logic [7:0] c);
		if (!is_blank(c)) begin
			if (is_letter(c)) begin
				begin_token(MODE_IDENT, TLEN_W'(1));
				kw_state = (c == CH_L) ? KW_L : (c == CH_P) ? KW_P : KW_NONE;
			end else if (is_digit(c)) begin
				begin_token(MODE_NUMBER, TLEN_W'(1));
			end else if (c == CH_QUOTE) begin
				begin_token(MODE_STRING, '0);
			end else if (c == CH_EQ) begin
				begin_token(MODE_EQ, TLEN_W'(1));
			end else begin
				add_token(single_kind(c), cur_line, cur_col, TLEN_W'(1));
			end
		end
		move_pos(c);
	endtask

	task automatic step_lexer(input stt_in_t r);
		logic [7:0] c;
		stt_out_t t;
		c = r.text_char;
		run_tokens.delete();
		if (r.end_of_text || c == CH_NUL) begin
			case (lx_mode)
				MODE_IDENT: close_token(word_kind());
				MODE_NUMBER: close_token(K_NUMBER);
				MODE_STRING: close_token(K_UNKNOWN);
				MODE_EQ: close_token(K_ASSIGN);
				default: ;
			endcase
			lx_mode = MODE_IDLE;
			add_token(K_EOF, cur_line, cur_col, '0);
		end else begin
			case (lx_mode)
				MODE_IDENT: begin
					if (is_letter(c)) begin
						grow_length();
						track_keyword(c);
						move_pos(c);
					end else begin
						close_token(word_kind());
						start_char(c);
					end
				end
				MODE_NUMBER: begin
					if (is_digit(c)) begin
						grow_length();
						move_pos(c);
					end else begin
						close_token(K_NUMBER);
						start_char(c);
					end
				end
				MODE_STRING: begin
					if (c == CH_QUOTE)
						close_token(K_STRING);
					else
						grow_length();
					move_pos(c);
				end
				MODE_EQ: begin
					if (c == CH_EQ) begin
						tok_len = TLEN_W'(2);
						close_token(K_COMPARE);
						move_pos(c);
					end else begin
						close_token(K_ASSIGN);
						start_char(c);
					end
				end
				default: begin
					lx_mode = MODE_IDLE;
					start_char(c);
				end
			endcase
		end
		if (run_tokens.size() != 0) begin
			t = run_tokens.pop_back();
			t.last_of_run = 1'b1;
			run_tokens.push_back(t);
		end
		foreach (run_tokens[i])
			tokens_due.push_back(run_tokens[i]);
	endtask

	task automatic send_request(input logic [7:0] ch, input logic eot);
		stt_in_t r;
		r.text_char = ch;
		r.end_of_text = eot;
		if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			text_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		text <= r;
		text_valid <= 1'b1;
		@(posedge clk);
		while (!text_ready)
			@(posedge clk);
		step_lexer(r);
		requests_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_request(s[i], 1'b0);
	endtask

	task automatic send_letters(input int n);
		logic [7:0] c;
		repeat (n) begin
			c = 8'($urandom_range(25));
			c = c + ($urandom_range(1) ? "a" : "A");
			send_request(c, 1'b0);
		end
	endtask

	task automatic send_string_body(input int n);
		logic [7:0] c;
		repeat (n) begin
			c = 8'($urandom_range(1, 255));
			if (c == CH_QUOTE)
				c = "'";
			send_request(c, 1'b0);
		end
	endtask

	task automatic send_random_fragment();
		int pick;
		logic [7:0] c;
		string ops;
		ops = "+-*/<>;()";
		pick = $urandom_range(99);
		if (pick < 25) begin
			if ($urandom_range(3) == 0) begin
				case ($urandom_range(5))
					0: send_text("let");
					1: send_text("print");
					2: send_text("le");
					3: send_text("prin");
					4: send_text("lets");
					default: send_text("printf");
				endcase
			end else begin
				send_letters($urandom_range(1, 8));
			end
		end else if (pick < 40) begin
			repeat ($urandom_range(1, 6)) begin
				c = 8'("0" + $urandom_range(9));
				send_request(c, 1'b0);
			end
		end else if (pick < 50) begin
			send_request(CH_QUOTE, 1'b0);
			send_string_body($urandom_range(0, 6));
			if ($urandom_range(9) != 0)
				send_request(CH_QUOTE, 1'b0);
		end else if (pick < 65) begin
			send_request(ops[$urandom_range(ops.len() - 1)], 1'b0);
		end else if (pick < 75) begin
			send_request(CH_EQ, 1'b0);
			if ($urandom_range(1))
				send_request(CH_EQ, 1'b0);
		end else if (pick < 90) begin
			case ($urandom_range(5))
				0: c = " ";
				1: c = 8'h09;
				2: c = CH_NL;
				3: c = 8'h0B;
				4: c = 8'h0C;
				default: c = 8'h0D;
			endcase
			send_request(c, 1'b0);
		end else if (pick < 97) begin
			send_request(8'($urandom_range(1, 255)), 1'b0);
		end else if (pick < 99) begin
			send_request(8'($urandom_range(255)), 1'b1);
		end else begin
			send_request(CH_NUL, 1'b0);
		end
	endtask

	task automatic test_keywords_and_compare();
		send_text("let printx=a==1;lets prin\n(p)");
		send_request(CH_NUL, 1'b1);
	endtask

	task automatic test_operators_and_bytes();
		send_text("+-*/<>;()\"\"");
		send_request(8'h80, 1'b0);
		send_request(8'hFF, 1'b0);
		send_request(8'h01, 1'b0);
		send_text(" \t");
		send_request(8'h0B, 1'b0);
		send_request(8'h0C, 1'b0);
		send_request(8'h0D, 1'b0);
	endtask

	task automatic test_end_of_text();
		send_text("print");
		send_request(8'hFF, 1'b1);
		send_text("=");
		send_request(CH_NUL, 1'b0);
		send_text("\"ab");
		send_request(CH_NUL, 1'b1);
		send_text("42");
		send_request(8'h41, 1'b1);
		send_request(CH_NUL, 1'b1);
	endtask

	task automatic test_long_tokens();
		logic [7:0] c;
		send_letters(260);
		send_request(" ", 1'b0);
		repeat (260) begin
			c = 8'("0" + $urandom_range(9));
			send_request(c, 1'b0);
		end
		send_request(CH_QUOTE, 1'b0);
		send_string_body(258);
		send_request(CH_QUOTE, 1'b0);
		send_request(CH_NUL, 1'b1);
	endtask

	task automatic test_random_text(input int tx_pct, input int rx_pct);
		int stop_at;
		tx_idle_pct = tx_pct;
		rx_idle_pct <= rx_pct;
		stop_at = requests_sent + PHASE_REQUESTS;
		while (requests_sent < stop_at)
			send_random_fragment();
	endtask

	task automatic test_output_stall();
		tx_idle_pct = 0;
		rx_idle_pct <= 0;
		hold_req <= hold_req + 1;
		repeat (20)
			send_text("x=7;");
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic report_field(input string field, input int unsigned want,
			input int unsigned got);
		failures++;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
	endtask

	always @(posedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			token_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			token_ready <= 1'b0;
		end else begin
			token_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
		if (arst_n && token_valid === 1'b1 && token_ready) begin
			if (tokens_due.size() == 0) begin
				failures++;
				$display("%0t: unexpected token, expected none, actual %h", $time, token);
			end else begin
				next_token = tokens_due.pop_front();
				if (token.token_kind !== next_token.token_kind)
					report_field("token_kind", 32'(next_token.token_kind),
						32'(token.token_kind));
				if (token.start_line !== next_token.start_line)
					report_field("start_line", 32'(next_token.start_line),
						32'(token.start_line));
				if (token.start_column !== next_token.start_column)
					report_field("start_column", 32'(next_token.start_column),
						32'(token.start_column));
				if (token.text_length !== next_token.text_length)
					report_field("text_length", 32'(next_token.text_length),
						32'(token.text_length));
				if (token.last_of_run !== next_token.last_of_run)
					report_field("last_of_run", 32'(next_token.last_of_run),
						32'(token.last_of_run));
			end
		end
	end

	initial begin
		reset_lexer();
		tx_idle_pct = 15;
		rx_idle_pct = 54;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_keywords_and_compare();
		test_operators_and_bytes();
		test_end_of_text();
		test_long_tokens();
		test_random_text(15, 54);
		test_random_text(54, 15);
		test_random_text(0, 0);
		test_output_stall();
		text_valid <= 1'b0;
		while (tokens_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
